/* hw/rtl/lssc_pkg.sv */
// Shared types and constants for the lamp soft-start controller.
// No dependencies; imported by every module of the block.
package lssc_pkg;

  // Event codes carried by an input request.
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_BUTTON = 2'd1,
    ACT_EDGE   = 2'd2
  } action_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INITIAL_DUTY   = 3'd0;
  localparam logic [2:0] CFG_RAMP_TIME_BASE = 3'd1;
  localparam logic [2:0] CFG_STOP_DELAY     = 3'd2;
  localparam logic [2:0] CFG_WINDOW_TICKS   = 3'd3;
  localparam logic [2:0] CFG_EDGES_NEEDED   = 3'd4;
  localparam logic [2:0] CFG_DEBOUNCE_TICKS = 3'd5;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // Register reset values.
  localparam logic [7:0]  InitialDutyRst   = 8'd52;
  localparam logic [15:0] RampTimeBaseRst  = 16'd2960;
  localparam logic [15:0] StopDelayRst     = 16'd1470;
  localparam logic [15:0] WindowTicksRst   = 16'd882;
  localparam logic [7:0]  EdgesNeededRst   = 8'd3;
  localparam logic [7:0]  DebounceTicksRst = 8'd118;

  // Step delay after reset, worked out from the reset register values.
  localparam int StepDelayRstInt = 2960 / (52 * 4);
  localparam logic [7:0] StepDelayRst =
    (StepDelayRstInt > 255) ? 8'd255 : 8'(StepDelayRstInt);

  // Duty sequence of the button.
  localparam logic [7:0] DutyMin       = 8'd25;
  localparam logic [7:0] DutyStep      = 8'd9;
  localparam logic [7:0] DutyWrapLimit = 8'd97;

  // Divider geometry: dividend is the ramp base, divisor is duty times four.
  localparam int DivDividendWidth = 16;
  localparam int DivDivisorWidth  = 10;
  localparam int DivCountWidth    = 4;

  // Controller state.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_LOAD,
    ST_DIV_WAIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic commit;
    logic div_start;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic recalc;
    logic div_done;
  } sts_t;

endpackage

/* hw/rtl/lamp_soft_start_controller_core.sv */
// Lamp soft-start controller, top level. ST_IDLE captures a request; ST_EXEC waits
// while the output is stalled, then commits the result to the result register, and
// the next request is taken even while that result waits. A request that saves a new
// duty then runs the 16-step serial step delay divider; a write to the duty or ramp
// base register in ST_IDLE holds inputs off as it runs. Reset is asynchronous and
// active low; capture, result and divider data registers are not reset.
module lamp_soft_start_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lssc_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [lssc_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic                              enable_level_i,
  input  logic                              aux_level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              pwm_connected_o,
  output logic [7:0]                        compare_value_o,
  output logic                              indicator_on_o,
  output logic                              save_strobe_o,
  output logic [7:0]                        saved_duty_o
);
  import lssc_pkg::*;

  cmd_t                        cmd;
  sts_t                        sts;
  logic [DivDividendWidth-1:0] div_dividend;
  logic [DivDivisorWidth-1:0]  div_divisor;
  logic                        div_done;
  logic [DivDividendWidth-1:0] div_quotient;

  // Sequencing.
  lssc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // State and update logic.
  lssc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .enable_level_i  (enable_level_i),
    .aux_level_i     (aux_level_i),
    .div_dividend_o  (div_dividend),
    .div_divisor_o   (div_divisor),
    .div_done_i      (div_done),
    .div_quotient_i  (div_quotient),
    .pwm_connected_o (pwm_connected_o),
    .compare_value_o (compare_value_o),
    .indicator_on_o  (indicator_on_o),
    .save_strobe_o   (save_strobe_o),
    .saved_duty_o    (saved_duty_o)
  );

  // Step delay divider.
  lssc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

endmodule

/* hw/rtl/lssc_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lssc_pkg for the operand widths.
module lssc_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [lssc_pkg::DivDividendWidth-1:0] dividend_i,
  input  logic [lssc_pkg::DivDivisorWidth-1:0]  divisor_i,
  output logic                                 done_o,
  output logic [lssc_pkg::DivDividendWidth-1:0] quotient_o
);
  import lssc_pkg::*;

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [DivCountWidth-1:0]    cnt_q, cnt_d;
  logic [DivDivisorWidth-1:0]  rem_q, rem_d;
  logic [DivDivisorWidth-1:0]  div_q, div_d;
  logic [DivDividendWidth-1:0] quo_q, quo_d;
  logic [DivDivisorWidth:0]    trial;
  logic                        fits;

  // One step: shift the next dividend bit into the remainder and try a subtract.
  // A zero divisor always fits, so the quotient comes out all ones.
  assign trial = {rem_q, quo_q[DivDividendWidth-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DivDivisorWidth'(trial - {1'b0, div_q}) : trial[DivDivisorWidth-1:0];
      quo_d = {quo_q[DivDividendWidth-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {DivCountWidth{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hw/rtl/lssc_datapath.sv */
// Datapath: configuration registers, control-loop state, one-pass update logic
// and the result register. Depends on lssc_pkg.
module lssc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lssc_pkg::cmd_t                    cmd_i,
  output lssc_pkg::sts_t                    sts_o,
  input  logic                              cfg_we_i,
  input  logic [lssc_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [lssc_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic [1:0]                        action_i,
  input  logic                              enable_level_i,
  input  logic                              aux_level_i,
  output logic [lssc_pkg::DivDividendWidth-1:0] div_dividend_o,
  output logic [lssc_pkg::DivDivisorWidth-1:0]  div_divisor_o,
  input  logic                              div_done_i,
  input  logic [lssc_pkg::DivDividendWidth-1:0] div_quotient_i,
  output logic                              pwm_connected_o,
  output logic [7:0]                        compare_value_o,
  output logic                              indicator_on_o,
  output logic                              save_strobe_o,
  output logic [7:0]                        saved_duty_o
);
  import lssc_pkg::*;

  // Configuration registers.
  logic [15:0] ramp_base_q, stop_delay_q, window_ticks_q;
  logic [7:0]  edges_needed_q, debounce_q;

  // Captured request.
  logic [1:0] action_q;
  logic       enable_q, aux_q;

  // Control-loop state.
  logic ramp_needed_q, ramp_needed_d;
  logic running_q, running_d;
  logic btn_pending_q, btn_pending_d;
  logic sda_q, sda_d;
  logic win_active_q, win_active_d;
  logic edge_pending_q, edge_pending_d;
  logic forced_off_q, forced_off_d;
  logic btn_armed_q, btn_armed_d;
  logic aux_armed_q, aux_armed_d;
  logic indicator_q, indicator_d;
  logic [7:0]  shared_ticks_q, shared_ticks_d;
  logic [15:0] stop_ticks_q, stop_ticks_d;
  logic [15:0] win_count_q, win_count_d;
  logic [7:0]  edge_count_q, edge_count_d;
  logic [7:0]  duty_q, duty_d;
  logic [7:0]  step_delay_q;
  logic [7:0]  compare_q, compare_d;
  logic        strobe_d;
  logic [7:0]  saved_d;
  logic        recalc;

  // Result register.
  logic       res_running_q, res_indicator_q, res_strobe_q;
  logic [7:0] res_compare_q, res_saved_q;

  // One pass of the control loop on the captured request.
  always_comb begin
    ramp_needed_d  = ramp_needed_q;
    running_d      = running_q;
    btn_pending_d  = btn_pending_q;
    sda_d          = sda_q;
    win_active_d   = win_active_q;
    edge_pending_d = edge_pending_q;
    forced_off_d   = forced_off_q;
    btn_armed_d    = btn_armed_q;
    aux_armed_d    = aux_armed_q;
    indicator_d    = indicator_q;
    shared_ticks_d = shared_ticks_q;
    stop_ticks_d   = stop_ticks_q;
    win_count_d    = win_count_q;
    edge_count_d   = edge_count_q;
    duty_d         = duty_q;
    compare_d      = compare_q;
    strobe_d       = 1'b0;
    saved_d        = '0;
    recalc         = 1'b0;

    // Event handling.
    case (action_q)
      ACT_TICK: begin
        shared_ticks_d = shared_ticks_q + 8'd1;
        stop_ticks_d   = stop_ticks_q + 16'd1;
        win_count_d    = win_count_q + 16'd1;
      end
      ACT_BUTTON: begin
        if (btn_armed_q) begin
          btn_armed_d    = 1'b0;
          shared_ticks_d = '0;
          btn_pending_d  = 1'b1;
          indicator_d    = 1'b1;
        end
      end
      ACT_EDGE: begin
        if (aux_armed_q && !aux_q) begin
          aux_armed_d    = 1'b0;
          shared_ticks_d = '0;
          if (!win_active_q) begin
            win_count_d  = '0;
            win_active_d = 1'b1;
          end
          edge_pending_d = 1'b1;
        end
      end
      default: ;
    endcase

    // Run, ramp and stop delay.
    if (enable_q && !forced_off_d) begin
      if (!running_d) begin
        running_d   = 1'b1;
        btn_armed_d = 1'b1;
      end else if (sda_d) begin
        sda_d = 1'b0;
      end
      if (ramp_needed_d && (shared_ticks_d >= step_delay_q)) begin
        if (compare_d < duty_d) begin
          compare_d      = compare_d + 8'd1;
          shared_ticks_d = '0;
        end else begin
          ramp_needed_d = 1'b0;
        end
      end
    end else if (running_d) begin
      if (!sda_d) begin
        sda_d        = 1'b1;
        stop_ticks_d = '0;
      end
      if (stop_ticks_d >= stop_delay_q) begin
        running_d     = 1'b0;
        compare_d     = 8'd1;
        ramp_needed_d = 1'b1;
        sda_d         = 1'b0;
        btn_armed_d   = 1'b0;
      end
    end

    // Debounced button: step the duty and save it.
    if (btn_pending_d && (shared_ticks_d >= debounce_q)) begin
      indicator_d   = 1'b0;
      btn_pending_d = 1'b0;
      duty_d        = (duty_d <= DutyWrapLimit) ? duty_d + DutyStep : DutyMin;
      compare_d     = duty_d;
      recalc        = 1'b1;
      strobe_d      = 1'b1;
      saved_d       = duty_d;
      btn_armed_d   = 1'b1;
    end

    // Debounced aux edge.
    if (edge_pending_d && (shared_ticks_d >= debounce_q)) begin
      edge_pending_d = 1'b0;
      edge_count_d   = edge_count_d + 8'd1;
      aux_armed_d    = 1'b1;
    end

    // Window end: enough edges with aux high toggles forced-off mode.
    if (win_active_d && (win_count_d >= window_ticks_q)) begin
      if ((edge_count_d >= edges_needed_q) && aux_q) begin
        if (!forced_off_d) begin
          forced_off_d = 1'b1;
          indicator_d  = 1'b1;
          if (running_d) begin
            running_d     = 1'b0;
            compare_d     = 8'd1;
            ramp_needed_d = 1'b1;
            sda_d         = 1'b0;
            btn_armed_d   = 1'b0;
          end
        end else begin
          forced_off_d = 1'b0;
          indicator_d  = 1'b0;
        end
      end
      edge_count_d = '0;
      win_active_d = 1'b0;
    end
  end

  // Configuration writes, state commit and step delay update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_base_q    <= RampTimeBaseRst;
      stop_delay_q   <= StopDelayRst;
      window_ticks_q <= WindowTicksRst;
      edges_needed_q <= EdgesNeededRst;
      debounce_q     <= DebounceTicksRst;
      ramp_needed_q  <= 1'b1;
      running_q      <= 1'b0;
      btn_pending_q  <= 1'b0;
      sda_q          <= 1'b0;
      win_active_q   <= 1'b0;
      edge_pending_q <= 1'b0;
      forced_off_q   <= 1'b0;
      btn_armed_q    <= 1'b0;
      aux_armed_q    <= 1'b1;
      indicator_q    <= 1'b0;
      shared_ticks_q <= '0;
      stop_ticks_q   <= '0;
      win_count_q    <= '0;
      edge_count_q   <= '0;
      duty_q         <= InitialDutyRst;
      step_delay_q   <= StepDelayRst;
      compare_q      <= 8'd1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INITIAL_DUTY:   duty_q         <= cfg_data_i[7:0];
          CFG_RAMP_TIME_BASE: ramp_base_q    <= cfg_data_i;
          CFG_STOP_DELAY:     stop_delay_q   <= cfg_data_i;
          CFG_WINDOW_TICKS:   window_ticks_q <= cfg_data_i;
          CFG_EDGES_NEEDED:   edges_needed_q <= cfg_data_i[7:0];
          CFG_DEBOUNCE_TICKS: debounce_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        ramp_needed_q  <= ramp_needed_d;
        running_q      <= running_d;
        btn_pending_q  <= btn_pending_d;
        sda_q          <= sda_d;
        win_active_q   <= win_active_d;
        edge_pending_q <= edge_pending_d;
        forced_off_q   <= forced_off_d;
        btn_armed_q    <= btn_armed_d;
        aux_armed_q    <= aux_armed_d;
        indicator_q    <= indicator_d;
        shared_ticks_q <= shared_ticks_d;
        stop_ticks_q   <= stop_ticks_d;
        win_count_q    <= win_count_d;
        edge_count_q   <= edge_count_d;
        duty_q         <= duty_d;
        compare_q      <= compare_d;
      end
      // Quotients above 255 saturate.
      if (div_done_i) begin
        step_delay_q <= (|div_quotient_i[DivDividendWidth-1:8]) ? 8'd255
                                                                : div_quotient_i[7:0];
      end
    end
  end

  // Request capture and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_i;
      enable_q <= enable_level_i;
      aux_q    <= aux_level_i;
    end
    if (cmd_i.commit) begin
      res_running_q   <= running_d;
      res_compare_q   <= compare_d;
      res_indicator_q <= indicator_d;
      res_strobe_q    <= strobe_d;
      res_saved_q     <= saved_d;
    end
  end

  // Step delay is base / (duty * 4), the same as dividing by duty then four.
  assign div_dividend_o = ramp_base_q;
  assign div_divisor_o  = {duty_q, 2'b00};

  assign sts_o.recalc   = recalc;
  assign sts_o.div_done = div_done_i;

  assign pwm_connected_o = res_running_q;
  assign compare_value_o = res_compare_q;
  assign indicator_on_o  = res_indicator_q;
  assign save_strobe_o   = res_strobe_q;
  assign saved_duty_o    = res_saved_q;

endmodule

/* hw/rtl/lssc_ctrl.sv */
// Controller state machine: request handshake, commit sequencing and divider
// start. Depends on lssc_pkg.
module lssc_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic                              cfg_we_i,
  input  logic [lssc_pkg::CfgIndexWidth-1:0] cfg_index_i,
  output lssc_pkg::cmd_t                    cmd_o,
  input  lssc_pkg::sts_t                    sts_i
);
  import lssc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   out_free;
  logic   cfg_recalc;

  // Inputs are held off during any configuration write.
  assign in_stall_o = (state_q != ST_IDLE) || cfg_we_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_recalc = cfg_we_i &&
                      (cfg_index_i inside {CFG_INITIAL_DUTY, CFG_RAMP_TIME_BASE});

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q && out_stall_i;
    cmd_o.load_item = 1'b0;
    cmd_o.commit    = 1'b0;
    cmd_o.div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cfg_recalc) begin
          state_d = ST_DIV_LOAD;
        end else if (in_accept) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = sts_i.recalc ? ST_DIV_LOAD : ST_IDLE;
        end
      end
      ST_DIV_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
